FILE: design/bpalm_pkg.sv
// Shared widths, constants, tables and controller/datapath interface types of the level meter.
`timescale 1ns / 1ps
`default_nettype none

package bpalm_pkg;

    // Default for the largest number of readings in one block.
    localparam int MAX_BLOCK_DEF = 64;

    // Field widths.
    localparam int PWR_W   = 16;
    localparam int LEVEL_W = 7;
    localparam int SEQ_W   = 16;
    localparam int STAMP_W = 32;
    localparam int BLK_W   = 7;

    // Datapath widths.
    localparam int SUM_W   = 44;   // Q24 linear power sum
    localparam int ITER_W  = 6;    // holds up to SUM_W - 1
    localparam int STEP_W  = 4;    // indexes the 16 exponent and log steps
    localparam int EXP_STEPS = 16;
    localparam int M_W     = 31;   // Q30 mantissa, below 2.0
    localparam int N_W     = 22;   // Q16 log2 exponent plus 24*65536
    localparam int P_W     = 47;   // scaled reading plus offset
    localparam int LVL_W   = 44;   // level in Q32, signed
    localparam int LOG_W   = 23;   // log2 in Q16, signed

    localparam logic [BLK_W-1:0] BLOCK_LEN_RESET = 7'd10;

    localparam logic signed [PWR_W-1:0] PWR_MIN = -16'sd20480;
    localparam logic signed [PWR_W-1:0] PWR_MAX = 16'sd10240;

    // log2(10) in Q28; dividing the product by 2560 * 4096 gives log2 in Q16.
    localparam logic [29:0] LOG2_10_Q28 = 30'd891723283;
    // 24 * 65536 * 2560 * 4096: moves the exponent from Q0 to Q24 before the divide.
    localparam logic signed [P_W-1:0] EXP_OFFSET = 47'sd16492674416640;
    // ceil(2^26 / 5): exact floor division by five for 24-bit values.
    localparam logic [23:0] RECIP5 = 24'd13421773;

    // 20 * log10(2) in Q16 scaled by 2^16, and level offsets in Q32.
    localparam logic [18:0] LEVEL_PER_LOG2 = 19'd394566;
    localparam logic signed [LVL_W-1:0] LVL_FULL  = 44'sd429496729600;
    localparam logic signed [LVL_W-1:0] LVL_TWO   = 44'sd8589934592;
    localparam logic signed [LVL_W-1:0] LVL_RAISE = 44'sd150323855360;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN    = 7'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_RAISED = 7'd35;

    // Entry j holds R[j+1] = floor(sqrt(R[j] * 2^30)), R[0] = 2^31, i.e. 2^(2^-(j+1)) in Q30.
    typedef logic [EXP_STEPS-1:0][M_W-1:0] root_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic root_tab_t make_root_tab();
        root_tab_t   tab;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int j = 0; j < EXP_STEPS; j++) begin
            r      = isqrt64(r << 30);
            tab[j] = r[M_W-1:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT_TAB = make_root_tab();

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture;
        logic              conv;
        logic              scale;
        logic              exp_step;
        logic              shift;
        logic              acc;
        logic              div_step;
        logic              norm_step;
        logic              log_load;
        logic              log_step;
        logic              lvl;
        logic              finish;
        logic [ITER_W-1:0] iter;
    } bpalm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_full;
        logic mean_zero;
        logic norm_done;
        logic out_free;
    } bpalm_status_t;

endpackage

`default_nettype wire

FILE: design/bpalm_ctrl.sv
// Sequencing state machine of the level meter: issues datapath commands and counts iterations.
`timescale 1ns / 1ps
`default_nettype none

module bpalm_ctrl
    import bpalm_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire bpalm_status_t status,
    output bpalm_cmd_t         cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CONV   = 11'b00000000010,
        S_SCALE  = 11'b00000000100,
        S_EXP    = 11'b00000001000,
        S_SHIFT  = 11'b00000010000,
        S_ACC    = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_NORM   = 11'b00010000000,
        S_LOG    = 11'b00100000000,
        S_LVL    = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } ctrl_state_t;

    localparam logic [ITER_W-1:0] EXP_LAST = ITER_W'(EXP_STEPS - 1);
    localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(SUM_W - 1);

    ctrl_state_t       state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        cmd.iter   = iter_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                iter_next  = '0;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                cmd.exp_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == EXP_LAST)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc   = 1'b1;
                iter_next = '0;
                if (status.block_full)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == DIV_LAST)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                iter_next = '0;
                if (status.mean_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (status.norm_done)
                begin
                    cmd.log_load = 1'b1;
                    state_next   = S_LOG;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_LOG:
            begin
                cmd.log_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == EXP_LAST)
                begin
                    state_next = S_LVL;
                end
            end
            S_LVL:
            begin
                cmd.lvl    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/bpalm_dp.sv
// Datapath of the level meter: dB to linear, block sum, divider, log2 and level mapping.
`timescale 1ns / 1ps
`default_nettype none

module bpalm_dp
    import bpalm_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [BLK_W-1:0]           cfg_write_data,
    input  wire logic signed [PWR_W-1:0]    power_db,
    input  wire logic                       out_ready,
    input  wire bpalm_cmd_t                 cmd,
    output bpalm_status_t                   status,
    output logic                            out_valid,
    output logic [LEVEL_W-1:0]              level,
    output logic [SEQ_W-1:0]                sequence_number,
    output logic [STAMP_W-1:0]              time_stamp
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int CMP_W = (CNT_W > BLK_W) ? CNT_W : BLK_W;

    // Control state.
    logic [BLK_W-1:0]   block_len_reg, block_len_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers.
    logic signed [PWR_W-1:0] x_reg, x_next;
    logic signed [P_W-1:0]   q_reg, q_next;
    logic [N_W-1:0]          n_reg, n_next;
    logic                    lin_zero_reg, lin_zero_next;
    logic [M_W-1:0]          m_reg, m_next;
    logic [SUM_W-1:0]        v_reg, v_next;
    logic [SUM_W-1:0]        mean_reg, mean_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [ITER_W-1:0]       k_reg, k_next;
    logic [M_W-1:0]          y_reg, y_next;
    logic [EXP_STEPS-1:0]    frac_reg, frac_next;
    logic signed [LVL_W-1:0] lvl_reg, lvl_next;
    logic [LEVEL_W-1:0]      level_reg, level_next;

    // Combinational helpers.
    logic signed [P_W-1:0]   conv_prod;
    logic [47:0]             scale_prod;
    logic [STEP_W-1:0]       step_idx;
    logic [STEP_W-1:0]       frac_idx;
    logic [EXP_STEPS-1:0]    n_frac;
    logic [2*M_W-1:0]        exp_prod;
    logic [5:0]              exp_int;
    logic [SUM_W:0]          sum_add;
    logic [SUM_W-1:0]        sum_new;
    logic [CMP_W-1:0]        blk_ext;
    logic [CMP_W-1:0]        limit;
    logic [CMP_W-1:0]        cnt_inc;
    logic [CNT_W:0]          div_shift;
    logic [CNT_W:0]          div_diff;
    logic                    div_ge;
    logic [2*M_W-1:0]        log_prod;
    logic [M_W:0]            log_sq;
    logic [6:0]              log_int;
    logic signed [LOG_W-1:0] log2_val;
    logic signed [LVL_W-1:0] lvl_prod;
    logic [LEVEL_W-1:0]      level_calc;
    logic                    mean_zero;
    logic                    out_free;

    assign mean_zero = (mean_reg == '0);
    assign out_free  = !out_valid_reg || out_ready;

    // Block end comes when this reading reaches the clamped block length.
    assign blk_ext = CMP_W'(block_len_reg);
    always_comb
    begin
        if (blk_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (blk_ext > CMP_W'(MAX_BLOCK))
        begin
            limit = CMP_W'(MAX_BLOCK);
        end
        else
        begin
            limit = blk_ext;
        end
    end
    assign cnt_inc = CMP_W'(cnt_reg) + CMP_W'(1);

    assign status.block_full = (cnt_inc >= limit);
    assign status.mean_zero  = mean_zero;
    assign status.norm_done  = mean_reg[SUM_W-1];
    assign status.out_free   = out_free;

    // Reading times log2(10) plus the Q24 offset.
    assign conv_prod = $signed({{(P_W-PWR_W){x_reg[PWR_W-1]}}, x_reg})
                     * $signed({{(P_W-30){1'b0}}, LOG2_10_Q28});

    // Floor divide by 5 * 2^21.
    assign scale_prod = {24'd0, q_reg[44:21]} * {24'd0, RECIP5};

    // One fraction bit per step, most significant first.
    assign step_idx = cmd.iter[STEP_W-1:0];
    assign frac_idx = STEP_W'(EXP_STEPS - 1) - step_idx;
    assign n_frac   = n_reg[EXP_STEPS-1:0];
    assign exp_prod = {{M_W{1'b0}}, m_reg} * {{M_W{1'b0}}, ROOT_TAB[step_idx]};
    assign exp_int  = n_reg[N_W-1:EXP_STEPS];

    assign sum_add = {1'b0, sum_reg} + {1'b0, v_reg};
    assign sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    // Restoring divider, one quotient bit per step.
    assign div_shift = {rem_reg, mean_reg[SUM_W-1]};
    assign div_diff  = div_shift - {1'b0, cnt_reg};
    assign div_ge    = (div_shift >= {1'b0, cnt_reg});

    // Squaring step of the log2 fraction.
    assign log_prod = {{M_W{1'b0}}, y_reg} * {{M_W{1'b0}}, y_reg};
    assign log_sq   = log_prod[2*M_W-1:M_W-1];

    assign log_int  = {1'b0, k_reg} - 7'd24;
    assign log2_val = $signed({log_int, frac_reg});
    assign lvl_prod = $signed({{(LVL_W-LOG_W){log2_val[LOG_W-1]}}, log2_val})
                    * $signed({{(LVL_W-19){1'b0}}, LEVEL_PER_LOG2}) + LVL_FULL;

    always_comb
    begin
        if (mean_zero || lvl_reg < 0)
        begin
            level_calc = LEVEL_MIN;
        end
        else if (lvl_reg > LVL_FULL)
        begin
            level_calc = LEVEL_MAX;
        end
        else if (lvl_reg > LVL_TWO && lvl_reg < LVL_RAISE)
        begin
            level_calc = LEVEL_RAISED;
        end
        else
        begin
            level_calc = lvl_reg[32 +: LEVEL_W];
        end
    end

    always_comb
    begin
        block_len_next = block_len_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        seq_next       = seq_reg;
        stamp_next     = stamp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        x_next         = x_reg;
        q_next         = q_reg;
        n_next         = n_reg;
        lin_zero_next  = lin_zero_reg;
        m_next         = m_reg;
        v_next         = v_reg;
        mean_next      = mean_reg;
        rem_next       = rem_reg;
        k_next         = k_reg;
        y_next         = y_reg;
        frac_next      = frac_reg;
        lvl_next       = lvl_reg;
        level_next     = level_reg;

        if (cfg_write_en)
        begin
            block_len_next = cfg_write_data;
        end
        if (cmd.capture)
        begin
            if (power_db < PWR_MIN)
            begin
                x_next = PWR_MIN;
            end
            else if (power_db > PWR_MAX)
            begin
                x_next = PWR_MAX;
            end
            else
            begin
                x_next = power_db;
            end
        end
        if (cmd.conv)
        begin
            q_next = conv_prod + EXP_OFFSET;
        end
        if (cmd.scale)
        begin
            lin_zero_next = q_reg[P_W-1];
            n_next        = scale_prod[47:26];
            m_next        = M_W'(1) << 30;
        end
        if (cmd.exp_step && n_frac[frac_idx])
        begin
            m_next = exp_prod[2*M_W-2:M_W-1];
        end
        if (cmd.shift)
        begin
            if (lin_zero_reg)
            begin
                v_next = '0;
            end
            else if (exp_int >= 6'd30)
            begin
                v_next = {{(SUM_W-M_W){1'b0}}, m_reg} << (exp_int - 6'd30);
            end
            else
            begin
                v_next = {{(SUM_W-M_W){1'b0}}, m_reg} >> (6'd30 - exp_int);
            end
        end
        if (cmd.acc)
        begin
            sum_next  = sum_new;
            cnt_next  = cnt_inc[CNT_W-1:0];
            mean_next = sum_new;
            rem_next  = '0;
            k_next    = ITER_W'(SUM_W - 1);
        end
        if (cmd.div_step)
        begin
            rem_next  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
            mean_next = {mean_reg[SUM_W-2:0], div_ge};
        end
        if (cmd.norm_step)
        begin
            mean_next = {mean_reg[SUM_W-2:0], 1'b0};
            k_next    = k_reg - 1'b1;
        end
        if (cmd.log_load)
        begin
            y_next    = mean_reg[SUM_W-1 -: M_W];
            frac_next = '0;
        end
        if (cmd.log_step)
        begin
            y_next    = log_sq[M_W] ? log_sq[M_W:1] : log_sq[M_W-1:0];
            frac_next = {frac_reg[EXP_STEPS-2:0], log_sq[M_W]};
        end
        if (cmd.lvl)
        begin
            lvl_next = lvl_prod;
        end
        if (cmd.finish)
        begin
            level_next     = level_calc;
            seq_next       = seq_reg + 1'b1;
            stamp_next     = stamp_reg + 1'b1;
            out_valid_next = 1'b1;
            sum_next       = '0;
            cnt_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg <= BLOCK_LEN_RESET;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            seq_reg       <= '0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            block_len_reg <= block_len_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            seq_reg       <= seq_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        q_reg        <= q_next;
        n_reg        <= n_next;
        lin_zero_reg <= lin_zero_next;
        m_reg        <= m_next;
        v_reg        <= v_next;
        mean_reg     <= mean_next;
        rem_reg      <= rem_next;
        k_reg        <= k_next;
        y_reg        <= y_next;
        frac_reg     <= frac_next;
        lvl_reg      <= lvl_next;
        level_reg    <= level_next;
    end

    assign out_valid       = out_valid_reg;
    assign level           = level_reg;
    assign sequence_number = seq_reg;
    assign time_stamp      = stamp_reg;

endmodule

`default_nettype wire

FILE: design/block_power_average_level_meter.sv
// Top level of the block power average level meter: controller and datapath.
// A reading that ends no block keeps the block busy through conversion, the exponent steps,
// the shift and the add; a block-ending reading then runs the 44-step divider, the 6 to
// 43-step normalizing shift and 16 log squaring steps (a zero mean skips the last two).
// A new reading is taken only once the block is idle again; the output register holds a result.
// Reset: rst_n is asynchronous, active low; block_length returns to 10, sums and counters to 0.
`timescale 1ns / 1ps
`default_nettype none

module block_power_average_level_meter
    import bpalm_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write_en,
    input  wire logic [BLK_W-1:0]        cfg_write_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [PWR_W-1:0] power_db,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [LEVEL_W-1:0]           level,
    output logic [SEQ_W-1:0]             sequence_number,
    output logic [STAMP_W-1:0]           time_stamp
);

    // The controller accepts one input transaction at a time. Each reading is clamped,
    // scaled to a base-two exponent, and raised to a Q24 linear power by sixteen
    // conditional multiplies with the root table. That value is added to a saturating sum.
    // When the block is full the sum is divided by the reading count one bit per cycle,
    // normalized, and its log2 is built by repeated squaring. The level mapping then
    // applies the clamp and the raise to 35 before the result is loaded into the output
    // register together with the incremented sequence number and time stamp.

    bpalm_cmd_t    cmd;
    bpalm_status_t status;

    bpalm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The output register inside the datapath lets a finished result wait for its
    // output transaction while the next reading is taken in.
    bpalm_dp #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .power_db        (power_db),
        .out_ready       (out_ready),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .level           (level),
        .sequence_number (sequence_number),
        .time_stamp      (time_stamp)
    );

endmodule

`default_nettype wire

FILE: design/bpalm_checker.sv
// Port-level assertions of the level meter and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module bpalm_checker
    import bpalm_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [LEVEL_W-1:0] level,
    input wire logic [SEQ_W-1:0]   sequence_number,
    input wire logic [STAMP_W-1:0] time_stamp
);

    // A waiting result holds its level and sequence number.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level) && $stable(sequence_number))
    else $error("result changed while stalled");

    // The level stays in range and never falls strictly between 2 and 35.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level <= LEVEL_MAX && !(level > 7'd2 && level < LEVEL_RAISED))
    else $error("level outside its allowed values");

    // Sequence number and time stamp advance together from reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> time_stamp[SEQ_W-1:0] == sequence_number)
    else $error("sequence number and time stamp disagree");

    // A reading keeps the block busy, so in_ready is low in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

endmodule

bind block_power_average_level_meter bpalm_checker u_bpalm_checker (.*);

`default_nettype wire

FILE: tb/block_power_average_level_meter_tb.sv
// Self-checking testbench for the block power average level meter.
`timescale 1ns / 1ps

module block_power_average_level_meter_tb;

    localparam int BLK_W     = bpalm_pkg::BLK_W;
    localparam int PWR_W     = bpalm_pkg::PWR_W;
    localparam int LEVEL_W   = bpalm_pkg::LEVEL_W;
    localparam int SEQ_W     = bpalm_pkg::SEQ_W;
    localparam int STAMP_W   = bpalm_pkg::STAMP_W;
    localparam int MAX_READS = bpalm_pkg::MAX_BLOCK_DEF;

    // Reading limits after saturation, in 1/256 dB.
    localparam int DB_FLOOR = -20480;
    localparam int DB_CEIL  = 10240;

    // dB to log2 conversion: x * log2(10) in Q28, divided by 2560 * 4096, gives Q16.
    localparam longint DB_TO_LOG2_Q28 = 64'sd891723283;
    localparam longint DB_DIVISOR     = 64'sd10485760;
    localparam longint Q24_OFFSET     = 64'sd1572864;   // 24 in Q16

    localparam longint unsigned SUM_MAX = (64'd1 << 44) - 64'd1;

    // Level mapping in Q32: 20 * log10(2) per Q16 unit of log2, plus 100.
    localparam longint LEVEL_PER_LOG2 = 64'sd394566;
    localparam longint LEVEL_TOP_Q32  = 64'sd429496729600;   // 100
    localparam longint LEVEL_RAISE_Q32 = 64'sd150323855360;  // 35
    localparam longint LEVEL_TWO_Q32  = 64'sd8589934592;     // 2

    localparam int TOTAL_READINGS = 1400;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SEQ_W-1:0]   seq;
        logic [STAMP_W-1:0] stamp;
    } level_report_t;

    // Clock, reset and every block input start at known values.
    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    cfg_write_en   = 1'b0;
    logic [BLK_W-1:0]        cfg_write_data = '0;
    logic                    in_valid       = 1'b0;
    logic                    in_ready;
    logic signed [PWR_W-1:0] power_db       = '0;
    logic                    out_valid;
    logic                    out_ready      = 1'b0;
    logic [LEVEL_W-1:0]      level;
    logic [SEQ_W-1:0]        sequence_number;
    logic [STAMP_W-1:0]      time_stamp;

    block_power_average_level_meter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .power_db        (power_db),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .level           (level),
        .sequence_number (sequence_number),
        .time_stamp      (time_stamp)
    );

    always #5 clk = ~clk;

    // Mirror of the block state, updated on every accepted reading.
    longint unsigned   root_q30 [0:16];
    logic [BLK_W-1:0]  blk_len_cfg = 7'd10;
    longint unsigned   lin_sum = 0;
    int                reads_in_block = 0;
    logic [SEQ_W-1:0]  seq_ctr = '0;
    logic [STAMP_W-1:0] stamp_ctr = '0;

    // Levels still owed by the block, oldest first.
    level_report_t     levels_due [$];

    // Readings waiting to be offered to the block.
    logic [PWR_W-1:0]  pwr_backlog [$];
    int                pushed_count = 0;
    int                taken_count  = 0;
    int                mismatch_count = 0;

    // Traffic shaping knobs; the stimulus process sets the modes and the hold-off per phase.
    bit                tx_gaps_on = 1'b0;
    int                burst_left = 0;
    int                gap_left   = 0;
    int                rx_mode    = 0;
    int                stall_left = 0;
    int                hold_left  = 0;
    level_report_t     got_report;
    level_report_t     want_report;

    // Integer square root, bit by bit.
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Linear power in Q24 of a saturated reading: 2^f from the root table, then a shift.
    function automatic longint unsigned db_to_linear_q24(input int x);
        longint          p;
        longint          e;
        longint          n;
        longint unsigned m;
        int              i;
        int              f;
        p = longint'(x) * DB_TO_LOG2_Q28;
        // The exponent is rounded toward minus infinity.
        if (p >= 0)
            e = p / DB_DIVISOR;
        else
            e = -((-p + DB_DIVISOR - 1) / DB_DIVISOR);
        n = e + Q24_OFFSET;
        if (n < 0)
            return 0;
        i = int'(n >> 16);
        f = int'(n & 64'hFFFF);
        m = 64'd1 << 30;
        for (int j = 1; j <= 16; j++)
            if (((f >> (16 - j)) & 1) != 0)
                m = (m * root_q30[j]) >> 30;
        if (i >= 30)
            return m << (i - 30);
        return m >> (30 - i);
    endfunction

    // log2 of a nonzero Q24 value, in Q16, by repeated squaring.
    function automatic longint log2_of_q24(input longint unsigned v);
        int              k;
        longint unsigned y;
        longint          frac;
        k    = 63;
        frac = 0;
        while (v[k] == 1'b0)
            k--;
        if (k >= 30)
            y = v >> (k - 30);
        else
            y = v << (30 - k);
        for (int b = 15; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y    = y >> 1;
                frac = frac | (longint'(1) << b);
            end
        end
        return longint'(k - 24) * 65536 + frac;
    endfunction

    // Folds one accepted reading into the running block and, at block end, queues the level.
    task automatic absorb_reading(input logic signed [PWR_W-1:0] raw);
        int              x;
        int              limit;
        longint unsigned v;
        longint unsigned mean;
        longint          lvl;
        level_report_t   rep;
        x = int'(raw);
        if (x < DB_FLOOR)
            x = DB_FLOOR;
        if (x > DB_CEIL)
            x = DB_CEIL;
        v = db_to_linear_q24(x);
        if (v > SUM_MAX - lin_sum)
            lin_sum = SUM_MAX;
        else
            lin_sum = lin_sum + v;
        reads_in_block++;

        // A zero length acts as one, anything above the maximum as the maximum.
        limit = int'(blk_len_cfg);
        if (limit == 0)
            limit = 1;
        if (limit > MAX_READS)
            limit = MAX_READS;
        if (reads_in_block < limit)
            return;

        mean      = lin_sum / longint'(reads_in_block);
        rep.level = '0;
        if (mean != 0) begin
            lvl = log2_of_q24(mean) * LEVEL_PER_LOG2 + LEVEL_TOP_Q32;
            if (lvl > LEVEL_TOP_Q32)
                lvl = LEVEL_TOP_Q32;
            if (lvl < 0)
                lvl = 0;
            // Low but audible levels are lifted so the meter shows activity.
            if (lvl > LEVEL_TWO_Q32 && lvl < LEVEL_RAISE_Q32)
                lvl = LEVEL_RAISE_Q32;
            rep.level = LEVEL_W'(lvl >>> 32);
        end
        lin_sum        = 0;
        reads_in_block = 0;
        seq_ctr        = seq_ctr + 1'b1;
        stamp_ctr      = stamp_ctr + 1'b1;
        rep.seq        = seq_ctr;
        rep.stamp      = stamp_ctr;
        levels_due.push_back(rep);
    endtask

    // Sender: offers backlog readings in bursts, holding each one until it is taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                absorb_reading(power_db);
                taken_count++;
            end
            // A new reading may go out only once the current one has been accepted.
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pwr_backlog.size() != 0) begin
                    power_db <= pwr_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if (tx_gaps_on) begin
                        burst_left = $urandom_range(0, 20);
                        gap_left   = $urandom_range(1, 12);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each level transaction and stalls on its own pattern.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got_report = '{level, sequence_number, time_stamp};
                if (levels_due.size() == 0) begin
                    $error("level transaction with none expected: level %0d seq %0d stamp %0d",
                           level, sequence_number, time_stamp);
                    mismatch_count++;
                end else begin
                    want_report = levels_due.pop_front();
                    if (got_report.level !== want_report.level) begin
                        $error("level: expected %0d, actual %0d",
                               want_report.level, got_report.level);
                        mismatch_count++;
                    end
                    if (got_report.seq !== want_report.seq) begin
                        $error("sequence_number: expected %0d, actual %0d",
                               want_report.seq, got_report.seq);
                        mismatch_count++;
                    end
                    if (got_report.stamp !== want_report.stamp) begin
                        $error("time_stamp: expected %0d, actual %0d",
                               want_report.stamp, got_report.stamp);
                        mismatch_count++;
                    end
                end
            end
            // The long hold-off lets the output register fill and back up the input.
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (rx_mode != 0 && $urandom_range(0, (rx_mode == 1) ? 7 : 2) == 0) begin
                stall_left = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_reading(input logic [PWR_W-1:0] v);
        pwr_backlog.push_back(v);
        pushed_count++;
    endtask

    // Mostly readings clustered around one level so blocks land across the whole
    // meter range, with some anywhere in range and some raw 16-bit values.
    task automatic feed_random(input int count);
        int center;
        int r;
        int v;
        center = int'($urandom_range(0, 30720)) - 20480;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                v = int'($urandom_range(0, 65535));
            end else if (r < 30) begin
                v = int'($urandom_range(0, 30720)) - 20480;
            end else begin
                v = center + int'($urandom_range(0, 1024)) - 512;
                if (v < -32768)
                    v = -32768;
            end
            queue_reading(PWR_W'(v));
        end
    endtask

    // Waits at the falling edge until every reading was taken and every level came back,
    // then lets the block finish any reading that ends no block.
    task automatic wait_quiet(input int settle);
        while (taken_count != pushed_count || in_valid || levels_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Register writes happen only while the block is idle; the predictor follows at once.
    task automatic write_block_length(input logic [BLK_W-1:0] v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        blk_len_cfg = v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic pick_traffic();
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_mode    = $urandom_range(0, 2);
    endtask

    task automatic run_phase(input logic [BLK_W-1:0] blen, input int count);
        write_block_length(blen);
        pick_traffic();
        feed_random(count);
        wait_quiet(40);
    endtask

    logic [PWR_W-1:0] directed_db [] = '{
        16'h8000, 16'hAFFF, 16'hB000, 16'hB001,   // below the floor, the floor, just above
        16'h2800, 16'h2801, 16'h7FFF,             // the ceiling and above it
        16'h0000, 16'hFFFF, 16'h0001,
        16'hCE00, 16'hCF00, 16'hCF2C,             // levels near zero and near two
        16'hD800, 16'hDD00, 16'hDF00, 16'hDF80,   // levels lifted to 35
        16'hE000, 16'hF600, 16'h0A00,             // just above 35, mid range, clipped at 100
        16'h5555, 16'hAAAA, 16'hEC00
    };

    initial begin
        root_q30[0] = 64'd1 << 31;
        for (int j = 1; j <= 16; j++)
            root_q30[j] = root_floor(root_q30[j - 1] << 30);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The reset block length of ten, before any register write.
        feed_random(30);
        wait_quiet(40);

        // Directed readings, one level per reading.
        write_block_length(7'd1);
        foreach (directed_db[k])
            queue_reading(directed_db[k]);
        wait_quiet(40);

        // Block length lowered with a block a quarter full: it ends at the next reading
        // and averages over the readings actually taken.
        write_block_length(7'd20);
        feed_random(5);
        wait_quiet(40);
        write_block_length(7'd3);
        feed_random(7);
        wait_quiet(40);

        // Receiver holds off for a long stretch while the sender keeps offering.
        write_block_length(7'd1);
        tx_gaps_on = 1'b0;
        rx_mode    = 0;
        hold_left  = 600;
        feed_random(40);
        wait_quiet(40);

        // Extremes of the register, including zero and values above the maximum.
        run_phase(7'd64, 140);
        run_phase(7'd0, 50);
        run_phase(7'd127, 130);
        run_phase(7'd65, 130);
        run_phase(7'd2, 60);
        run_phase(7'd63, 70);

        // Random settings, mostly short blocks so levels keep coming.
        while (pushed_count < TOTAL_READINGS) begin
            if ($urandom_range(0, 3) == 0)
                run_phase(BLK_W'($urandom_range(0, 127)), $urandom_range(30, 130));
            else
                run_phase(BLK_W'($urandom_range(1, 8)), $urandom_range(30, 90));
        end

        wait_quiet(200);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
design/bpalm_pkg.sv
design/bpalm_ctrl.sv
design/bpalm_dp.sv
design/block_power_average_level_meter.sv
design/bpalm_checker.sv
tb/block_power_average_level_meter_tb.sv
